>>> hdl/mrs_pkg.sv
// Shared constants and types for the mutable 2-D range sum block.
`timescale 1ns / 1ps
package mrs_pkg;
	localparam int MAX_ROWS  = 16;
	localparam int MAX_COLS  = 16;
	localparam int ROW_W     = 4;
	localparam int COL_W     = 4;
	localparam int DIM_W     = 5;
	localparam int CELL_AW   = ROW_W + COL_W;
	localparam int VALUE_W   = 32;
	localparam int DELTA_W   = VALUE_W + 1;
	localparam int SUM_W     = 40;
	localparam int BUF_DEPTH = MAX_ROWS + MAX_COLS + 1;
	localparam int CNT_W     = 6;
	localparam int REG_IDX_W = 1;

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_BUILD  = 2'd1,
		REQ_UPDATE = 2'd2,
		REQ_QUERY  = 2'd3
	} req_t;

	localparam logic [REG_IDX_W-1:0] REG_ROWS = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_COLS = 1'b1;

	typedef struct packed {
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [DELTA_W-1:0] delta;
	} pend_t;
endpackage

>>> hdl/mutable_2d_range_sum.sv
// Load and any flagged request go straight to the output register; build fills the column and suffix tables.
// Update searches the buffered deltas for its cell, then replaces that entry or appends a new one.
// Query adds the buffered deltas in its rectangle; a flushing update folds them into the grid and rebuilds.
// Requests are taken one at a time; the next is taken once the result is in the output register.
// Reset clears the control state and pending count and sets both sizes to 16; grid and tables
// hold no reset value.
`timescale 1ns / 1ps
module mutable_2d_range_sum (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [47:0]                    s_tdata,  // row_index, col_index, row_end, col_end, cell_value
	input  logic [1:0]                     s_tuser,  // req_type
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mrs_pkg::SUM_W-1:0]      m_tdata,  // region_sum
	output logic                           m_tuser,  // status
	input  logic                           cfg_we,
	input  logic [mrs_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [mrs_pkg::DIM_W-1:0]      cfg_data
);
	typedef enum logic [4:0] {
		S_IDLE, S_UPD_RD, S_UPD_DELTA, S_SRCH_RD, S_SRCH_CMP, S_APPEND, S_UPD_CHK,
		S_FL_RD, S_FL_GRID, S_FL_WR, S_B1_RD, S_B1_WR, S_B2_RD, S_B2_WR,
		S_Q_RD, S_Q_ACC, S_QP_RD, S_QP_ACC, S_DONE
	} state_t;

	state_t                         state_q;
	logic [mrs_pkg::DIM_W-1:0]      rows_q, cols_q, eff_r, eff_c;
	logic [mrs_pkg::ROW_W-1:0]      r0_q, r1_q, i_q;
	logic [mrs_pkg::COL_W-1:0]      c0_q, c1_q, j_q;
	logic [mrs_pkg::VALUE_W-1:0]    val_q;
	logic [mrs_pkg::DELTA_W-1:0]    delta_q;
	logic [mrs_pkg::CNT_W-1:0]      k_q, cnt_q;
	logic [mrs_pkg::SUM_W-1:0]      acc_q, res_q;
	logic                           stat_q, tv_q;
	logic [1:0]                     t_q;
	logic                           m_tvalid_q, m_tuser_q;
	logic [mrs_pkg::SUM_W-1:0]      m_tdata_q;

	// memories
	logic [mrs_pkg::VALUE_W-1:0] grid_mem [0:mrs_pkg::MAX_ROWS*mrs_pkg::MAX_COLS-1];
	logic [mrs_pkg::SUM_W-1:0]   suf_mem  [0:mrs_pkg::MAX_ROWS*mrs_pkg::MAX_COLS-1];
	logic [mrs_pkg::SUM_W-1:0]   col_mem  [0:mrs_pkg::MAX_ROWS*mrs_pkg::MAX_COLS-1];
	mrs_pkg::pend_t              pend_mem [0:mrs_pkg::BUF_DEPTH-1];
	logic [mrs_pkg::VALUE_W-1:0] grid_rd;
	logic [mrs_pkg::SUM_W-1:0]   suf_rd, col_rd;
	mrs_pkg::pend_t              pend_rd;

	logic [mrs_pkg::CELL_AW-1:0] grid_ra, grid_wa, suf_ra;
	logic [mrs_pkg::VALUE_W-1:0] grid_wd;
	logic                        grid_we, suf_we, col_we, pend_we;
	logic [mrs_pkg::SUM_W-1:0]   suf_wd, col_wd;
	logic [mrs_pkg::CNT_W-1:0]   pend_wa;

	// request fields
	logic                        in_acc;
	mrs_pkg::req_t               in_type;
	logic [mrs_pkg::ROW_W-1:0]   in_r0, in_r1;
	logic [mrs_pkg::COL_W-1:0]   in_c0, in_c1;
	logic [mrs_pkg::VALUE_W-1:0] in_val;
	logic                        cell_bad, rect_bad;

	// helpers
	logic [mrs_pkg::DIM_W-1:0]   tr, tc;
	logic [mrs_pkg::SUM_W-1:0]   b1_sum, b2_sum, delta_ext;
	logic [mrs_pkg::DELTA_W-1:0] delta_new;
	logic                        pend_hit, pend_in;
	logic [mrs_pkg::CNT_W-1:0]   rc_sum;
	logic [mrs_pkg::COL_W-1:0]   j_next;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign in_acc  = s_tvalid && s_tready;
	assign in_type = mrs_pkg::req_t'(s_tuser);
	assign in_r0   = s_tdata[3:0];
	assign in_c0   = s_tdata[7:4];
	assign in_r1   = s_tdata[11:8];
	assign in_c1   = s_tdata[15:12];
	assign in_val  = s_tdata[47:16];

	// clamp the in-use sizes to the grid
	always_comb begin
		eff_r = rows_q;
		if (rows_q == '0) eff_r = 5'd1;
		else if (rows_q > 5'(mrs_pkg::MAX_ROWS)) eff_r = 5'(mrs_pkg::MAX_ROWS);
		eff_c = cols_q;
		if (cols_q == '0) eff_c = 5'd1;
		else if (cols_q > 5'(mrs_pkg::MAX_COLS)) eff_c = 5'(mrs_pkg::MAX_COLS);
	end

	assign cell_bad = ({1'b0, in_r0} >= eff_r) || ({1'b0, in_c0} >= eff_c);
	assign rect_bad = (in_r0 > in_r1) || (in_c0 > in_c1) ||
		({1'b0, in_r1} >= eff_r) || ({1'b0, in_c1} >= eff_c);

	// corner of the current inclusion-exclusion term
	always_comb begin
		tr = (t_q[1]) ? ({1'b0, r1_q} + 5'd1) : {1'b0, r0_q};
		tc = (t_q[0]) ? ({1'b0, c1_q} + 5'd1) : {1'b0, c0_q};
	end

	assign j_next    = j_q + 4'd1;
	assign b1_sum    = acc_q + {{(mrs_pkg::SUM_W-mrs_pkg::VALUE_W){grid_rd[mrs_pkg::VALUE_W-1]}},
		grid_rd};
	assign b2_sum    = col_rd + ((5'({1'b0, j_q}) + 5'd1 < eff_c) ? suf_rd : '0);
	assign delta_new = {val_q[mrs_pkg::VALUE_W-1], val_q} -
		{grid_rd[mrs_pkg::VALUE_W-1], grid_rd};
	assign delta_ext = {{(mrs_pkg::SUM_W-mrs_pkg::DELTA_W){pend_rd.delta[mrs_pkg::DELTA_W-1]}},
		pend_rd.delta};
	assign pend_hit  = (pend_rd.row == r0_q) && (pend_rd.col == c0_q);
	assign pend_in   = (pend_rd.row >= r0_q) && (pend_rd.row <= r1_q) &&
		(pend_rd.col >= c0_q) && (pend_rd.col <= c1_q);
	assign rc_sum    = 6'(eff_r) + 6'(eff_c);

	// memory address and write selection
	always_comb begin
		grid_ra = {r0_q, c0_q};
		if (state_q == S_FL_GRID) grid_ra = {pend_rd.row, pend_rd.col};
		else if (state_q == S_B1_RD) grid_ra = {i_q, j_q};
		grid_we = 1'b0;
		grid_wa = {in_r0, in_c0};
		grid_wd = in_val;
		if (state_q == S_IDLE && in_acc && in_type == mrs_pkg::REQ_LOAD && !cell_bad) begin
			grid_we = 1'b1;
		end else if (state_q == S_FL_WR) begin
			grid_we = 1'b1;
			grid_wa = {pend_rd.row, pend_rd.col};
			grid_wd = grid_rd + pend_rd.delta[mrs_pkg::VALUE_W-1:0];
		end
		suf_ra  = (state_q == S_B2_RD) ? {i_q, j_next} : {tr[3:0], tc[3:0]};
		suf_we  = (state_q == S_B2_WR);
		suf_wd  = b2_sum;
		col_we  = (state_q == S_B1_WR);
		col_wd  = b1_sum;
		pend_we = (state_q == S_APPEND && cnt_q < 6'(mrs_pkg::BUF_DEPTH)) ||
			(state_q == S_SRCH_CMP && pend_hit);
		pend_wa = (state_q == S_APPEND) ? cnt_q : k_q;
	end

	// grid store
	always_ff @(posedge clk) begin
		if (grid_we) grid_mem[grid_wa] <= grid_wd;
		grid_rd <= grid_mem[grid_ra];
	end

	// suffix-sum tables
	always_ff @(posedge clk) begin
		if (suf_we) suf_mem[{i_q, j_q}] <= suf_wd;
		suf_rd <= suf_mem[suf_ra];
	end

	always_ff @(posedge clk) begin
		if (col_we) col_mem[{i_q, j_q}] <= col_wd;
		col_rd <= col_mem[{i_q, j_q}];
	end

	// pending delta buffer
	always_ff @(posedge clk) begin
		if (pend_we) pend_mem[pend_wa] <= '{row: r0_q, col: c0_q, delta: delta_q};
		pend_rd <= pend_mem[k_q];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 5'(mrs_pkg::MAX_ROWS);
			cols_q <= 5'(mrs_pkg::MAX_COLS);
		end else if (cfg_we) begin
			case (cfg_index)
				mrs_pkg::REG_ROWS: rows_q <= cfg_data;
				mrs_pkg::REG_COLS: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			k_q        <= '0;
			t_q        <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
			r0_q <= '0; c0_q <= '0; r1_q <= '0; c1_q <= '0;
			i_q <= '0; j_q <= '0;
			val_q <= '0; delta_q <= '0; acc_q <= '0; res_q <= '0;
			stat_q <= 1'b0; tv_q <= 1'b0;
		end else begin
			// raise the result flag in the hand-over state, drop it once taken
			if (state_q == S_DONE) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						r0_q   <= in_r0;
						c0_q   <= in_c0;
						r1_q   <= in_r1;
						c1_q   <= in_c1;
						val_q  <= in_val;
						res_q  <= '0;
						stat_q <= 1'b0;
						acc_q  <= '0;
						k_q    <= '0;
						t_q    <= '0;
						case (in_type)
							mrs_pkg::REQ_LOAD: begin
								stat_q  <= cell_bad;
								state_q <= S_DONE;
							end
							mrs_pkg::REQ_BUILD: begin
								i_q     <= 4'(eff_r - 5'd1);
								j_q     <= '0;
								state_q <= S_B1_RD;
							end
							mrs_pkg::REQ_UPDATE: begin
								stat_q  <= cell_bad;
								state_q <= cell_bad ? S_DONE : S_UPD_RD;
							end
							default: begin
								stat_q  <= rect_bad;
								state_q <= rect_bad ? S_DONE : S_Q_RD;
							end
						endcase
					end
				end
				S_UPD_RD: state_q <= S_UPD_DELTA;
				S_UPD_DELTA: begin
					delta_q <= delta_new;
					state_q <= (cnt_q == '0) ? S_APPEND : S_SRCH_RD;
				end
				S_SRCH_RD: state_q <= S_SRCH_CMP;
				S_SRCH_CMP: begin
					// replace in place on a hit, else append after the last entry
					if (pend_hit) state_q <= S_UPD_CHK;
					else if (k_q + 6'd1 == cnt_q) state_q <= S_APPEND;
					else begin
						k_q     <= k_q + 6'd1;
						state_q <= S_SRCH_RD;
					end
				end
				S_APPEND: begin
					if (cnt_q < 6'(mrs_pkg::BUF_DEPTH)) cnt_q <= cnt_q + 6'd1;
					state_q <= S_UPD_CHK;
				end
				S_UPD_CHK: begin
					if (cnt_q > rc_sum) begin
						k_q     <= '0;
						state_q <= S_FL_RD;
					end else state_q <= S_DONE;
				end
				S_FL_RD:   state_q <= S_FL_GRID;
				S_FL_GRID: state_q <= S_FL_WR;
				S_FL_WR: begin
					// fold each delta into the grid, then rebuild
					if (k_q + 6'd1 == cnt_q) begin
						i_q     <= 4'(eff_r - 5'd1);
						j_q     <= '0;
						acc_q   <= '0;
						state_q <= S_B1_RD;
					end else begin
						k_q     <= k_q + 6'd1;
						state_q <= S_FL_RD;
					end
				end
				S_B1_RD: state_q <= S_B1_WR;
				S_B1_WR: begin
					// column sums walk upward, one column at a time
					if (i_q == '0) begin
						acc_q <= '0;
						if (5'({1'b0, j_q}) + 5'd1 == eff_c) begin
							i_q <= '0;
						end else begin
							i_q <= 4'(eff_r - 5'd1);
							j_q <= j_next;
						end
					end else begin
						acc_q <= b1_sum;
						i_q   <= i_q - 4'd1;
					end
					state_q <= (i_q == '0 && 5'({1'b0, j_q}) + 5'd1 == eff_c) ? S_B2_RD :
						S_B1_RD;
				end
				S_B2_RD: state_q <= S_B2_WR;
				S_B2_WR: begin
					// rectangle sums walk leftward from the last column
					if (5'({1'b0, i_q}) + 5'd1 == eff_r) begin
						i_q <= '0;
						if (j_q == '0) begin
							cnt_q   <= '0;
							state_q <= S_DONE;
						end else begin
							j_q     <= j_q - 4'd1;
							state_q <= S_B2_RD;
						end
					end else begin
						i_q     <= i_q + 4'd1;
						state_q <= S_B2_RD;
					end
				end
				S_Q_RD: begin
					tv_q    <= (tr < eff_r) && (tc < eff_c);
					state_q <= S_Q_ACC;
				end
				S_Q_ACC: begin
					if (tv_q) acc_q <= (t_q == 2'd1 || t_q == 2'd2) ? acc_q - suf_rd :
						acc_q + suf_rd;
					t_q <= t_q + 2'd1;
					if (t_q == 2'd3) state_q <= (cnt_q == '0) ? S_DONE : S_QP_RD;
					else state_q <= S_Q_RD;
					if (t_q == 2'd3 && cnt_q == '0) begin
						res_q <= tv_q ? acc_q + suf_rd : acc_q;
					end
				end
				S_QP_RD: state_q <= S_QP_ACC;
				S_QP_ACC: begin
					// add buffered deltas that fall inside the rectangle
					if (k_q + 6'd1 == cnt_q) begin
						res_q   <= pend_in ? acc_q + delta_ext : acc_q;
						state_q <= S_DONE;
					end else begin
						if (pend_in) acc_q <= acc_q + delta_ext;
						k_q     <= k_q + 6'd1;
						state_q <= S_QP_RD;
					end
				end
				S_DONE: begin
					// hand the result over once the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= res_q;
						m_tuser_q  <= stat_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> hdl/mrs_checker.sv
// Port-level checks for the mutable 2-D range sum block.
`timescale 1ns / 1ps
module mrs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [mrs_pkg::SUM_W-1:0] m_tdata,
	input logic                      m_tuser
);
	// a taken request leaves the input closed right after it
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input open right after a request");

	// a result never appears in the cycle after a request is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
		else $error("result too early");

	// a flagged request carries a zero sum
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("error result with non-zero sum");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");
endmodule

bind mutable_2d_range_sum mrs_checker u_mrs_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
